// ===== hw/rtl/ftc_pkg.sv =====
// Shared types and constants for the farthest-tile cache.
package ftc_pkg;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    localparam logic [2:0] CFG_LEFT   = 3'd0;
    localparam logic [2:0] CFG_TOP    = 3'd1;
    localparam logic [2:0] CFG_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_CAP    = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_EVICT,
        ST_KILL,
        ST_INSERT,
        ST_OUT
    } t_state;

endpackage

// ===== hw/rtl/farthest_tile_cache_replacement.sv =====
// Top level of the farthest-tile cache: cell ring, distance unit and sequencer.
// A clear or unused request answers in the cycle after acceptance; a read or a hit
// answers after a full rotation of the ring. A write miss takes the lowest free slot,
// first evicting the farthest entry by a distance scan when the cache is full.
// One transaction at a time: new requests stall until the last result is accepted.
// Reset (synchronous, active low) empties every slot and restores the registers.
module farthest_tile_cache_replacement
    import ftc_pkg::*;
#(
    parameter int SLOTS      = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [2:0]                   i_cfg_index,
    input  logic [15:0]                  i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_req_type,
    input  logic signed [COORD_BITS-1:0] i_tile_x,
    input  logic signed [COORD_BITS-1:0] i_tile_y,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_is_eviction,
    output logic signed [COORD_BITS-1:0] o_evicted_x,
    output logic signed [COORD_BITS-1:0] o_evicted_y,
    output logic                         o_hit,
    output logic [3:0]                   o_slot,
    output logic                         o_found,
    output logic                         o_last
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int DW = 2*COORD_BITS + 3;

    t_state r_state, n_state;

    logic signed [COORD_BITS-1:0] r_left, r_top;
    logic [15:0] r_width, r_height;
    logic [4:0]  r_cap;
    logic [1:0]  r_req;
    logic [COORD_BITS-1:0] r_x, r_y;
    logic [CW-1:0] r_occ;
    logic [IW:0]   r_cnt, n_cnt;
    logic [IW-1:0] r_pos;
    logic          r_hit_seen;
    logic [IW-1:0] r_hit_slot;
    logic          r_free_seen;
    logic [IW-1:0] r_free_slot;
    logic          r_best_ok;
    logic [DW-1:0] r_best;
    logic [IW-1:0] r_best_slot;
    logic [1:0]    r_dv;
    logic [IW-1:0] r_dslot [2];

    logic          r_out_valid, r_out_ev, r_out_hit, r_out_found, r_out_last;
    logic [COORD_BITS-1:0] r_out_x, r_out_y;
    logic [3:0]    r_out_slot;
    logic          out_set, n_out_ev, n_out_hit, n_out_found, n_out_last;
    logic [COORD_BITS-1:0] n_out_x, n_out_y;
    logic [3:0]    n_out_slot;

    logic [SLOTS-1:0] c_valid;
    logic [COORD_BITS-1:0] c_col [SLOTS], c_row [SLOTS];
    logic shift, clr, load_now, kill_now, sample;
    logic [DW-1:0] dist2;
    logic [CW-1:0] cap_eff;
    logic head_match, need_evict, lower_free, take_best;
    logic accept_in, accept_out;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0; r_top <= '0; r_width <= '0; r_height <= '0; r_cap <= 5'd16;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LEFT:   r_left   <= COORD_BITS'($signed(i_cfg_data));
                CFG_TOP:    r_top    <= COORD_BITS'($signed(i_cfg_data));
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_CAP:    r_cap    <= i_cfg_data[4:0];
                default:    ;
            endcase
        end
    end

    // Effective capacity, clamped to 1..SLOTS.
    always_comb begin
        if (r_cap == 5'd0)                     cap_eff = CW'(1);
        else if (32'(r_cap) > SLOTS)           cap_eff = CW'(SLOTS);
        else                                   cap_eff = CW'(r_cap);
    end

    // Ring of cells; the head (cell 0) is the slot at r_pos.
    genvar g;
    generate
        for (g = 0; g < SLOTS; g++) begin : g_cell
            localparam int NX = (g + 1) % SLOTS;
            ftc_cell #(.COORD_BITS(COORD_BITS)) u_cell (
                .i_clk, .i_rst_n,
                .i_shift(shift), .i_clear(clr),
                .i_load((g == 0) && load_now), .i_kill((g == 0) && kill_now),
                .i_valid(c_valid[NX]), .i_col(c_col[NX]), .i_row(c_row[NX]),
                .i_new_col(r_x), .i_new_row(r_y),
                .o_valid(c_valid[g]), .o_col(c_col[g]), .o_row(c_row[g])
            );
        end
    endgenerate

    ftc_dist #(.COORD_BITS(COORD_BITS)) u_dist (
        .i_clk, .i_x(c_col[0]), .i_y(c_row[0]), .i_left(r_left), .i_top(r_top),
        .i_width(r_width), .i_height(r_height), .o_dist2(dist2)
    );

    assign head_match = c_valid[0] && c_col[0] == r_x && c_row[0] == r_y;
    assign need_evict = (r_occ >= cap_eff) && (r_occ != '0);
    assign lower_free = !r_free_seen || (r_pos < r_free_slot);
    assign take_best  = r_dv[1] && (!r_best_ok || dist2 > r_best ||
                        (dist2 == r_best && r_dslot[1] < r_best_slot));
    assign accept_in  = i_valid && !o_stall;
    assign accept_out = o_valid && !i_stall;
    assign o_stall    = (r_state != ST_IDLE);

    // Sequencer: next state, cell controls and the next result.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        shift       = 1'b0;
        clr         = 1'b0;
        load_now    = 1'b0;
        kill_now    = 1'b0;
        sample      = 1'b0;
        out_set     = 1'b0;
        n_out_ev    = 1'b0;
        n_out_x     = '0;
        n_out_y     = '0;
        n_out_hit   = 1'b0;
        n_out_slot  = '0;
        n_out_found = 1'b0;
        n_out_last  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (accept_in) begin
                    if (i_req_type == REQ_READ || i_req_type == REQ_WRITE) begin
                        n_state = ST_LOOKUP;
                    end else begin
                        clr        = (i_req_type == REQ_CLEAR);
                        out_set    = 1'b1;
                        n_out_last = 1'b1;
                        n_state    = ST_OUT;
                    end
                end
            end
            ST_LOOKUP: begin
                // One full rotation compares every slot with the requested tag.
                shift = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == (IW+1)'(SLOTS - 1)) begin
                    n_cnt = '0;
                    if (r_hit_seen || head_match) begin
                        out_set     = 1'b1;
                        n_out_hit   = 1'b1;
                        n_out_found = 1'b1;
                        n_out_last  = 1'b1;
                        n_out_slot  = head_match ? 4'(r_pos) : 4'(r_hit_slot);
                        n_state     = ST_OUT;
                    end else if (r_req == REQ_READ) begin
                        out_set    = 1'b1;
                        n_out_last = 1'b1;
                        n_state    = ST_OUT;
                    end else if (need_evict) begin
                        n_state = ST_EVICT;
                    end else begin
                        n_state = ST_INSERT;
                    end
                end
            end
            ST_EVICT: begin
                // SLOTS shifts feed the distance unit, then its pipeline drains before the scan ends.
                sample = (r_cnt < (IW+1)'(SLOTS));
                shift  = sample;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == (IW+1)'(SLOTS + 1)) begin
                    n_cnt   = '0;
                    n_state = ST_KILL;
                end
            end
            ST_KILL: begin
                // Rotate the victim to the head, then drop it and report it.
                if (r_pos == r_best_slot) begin
                    kill_now    = 1'b1;
                    out_set     = 1'b1;
                    n_out_ev    = 1'b1;
                    n_out_x     = c_col[0];
                    n_out_y     = c_row[0];
                    n_out_slot  = 4'(r_pos);
                    n_out_found = 1'b1;
                    n_state     = ST_OUT;
                end else begin
                    shift = 1'b1;
                end
            end
            ST_INSERT: begin
                // Rotate the lowest free slot to the head and load the tag there; with none, report not found.
                if (!r_free_seen) begin
                    out_set    = 1'b1;
                    n_out_last = 1'b1;
                    n_state    = ST_OUT;
                end else if (r_pos == r_free_slot) begin
                    load_now    = 1'b1;
                    out_set     = 1'b1;
                    n_out_slot  = 4'(r_pos);
                    n_out_found = 1'b1;
                    n_out_last  = 1'b1;
                    n_state     = ST_OUT;
                end else begin
                    shift = 1'b1;
                end
            end
            ST_OUT: begin
                if (accept_out) begin
                    if (r_out_last)      n_state = ST_IDLE;
                    else if (need_evict) n_state = ST_EVICT;
                    else                 n_state = ST_INSERT;
                    n_cnt = '0;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer registers, scan trackers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_occ       <= '0;
            r_req       <= REQ_READ;
            r_x         <= '0;
            r_y         <= '0;
            r_hit_seen  <= 1'b0;
            r_hit_slot  <= '0;
            r_free_seen <= 1'b0;
            r_free_slot <= '0;
            r_best_ok   <= 1'b0;
            r_best      <= '0;
            r_best_slot <= '0;
            r_dv        <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (shift) begin
                r_pos <= (r_pos == IW'(SLOTS - 1)) ? '0 : r_pos + 1'b1;
            end
            if (accept_in) begin
                r_req       <= i_req_type;
                r_x         <= i_tile_x;
                r_y         <= i_tile_y;
                r_hit_seen  <= 1'b0;
                r_free_seen <= 1'b0;
            end
            if (r_state == ST_LOOKUP && head_match) begin
                r_hit_seen <= 1'b1;
                r_hit_slot <= r_pos;
            end
            // Lowest free slot: seen during the lookup or freed by an eviction.
            if ((r_state == ST_LOOKUP && !c_valid[0] && lower_free) ||
                (kill_now && lower_free)) begin
                r_free_seen <= 1'b1;
                r_free_slot <= r_pos;
            end
            // Farthest entry; equal distances keep the lower slot.
            if (r_state != ST_EVICT) begin
                r_best_ok <= 1'b0;
            end else if (take_best) begin
                r_best_ok   <= 1'b1;
                r_best      <= dist2;
                r_best_slot <= r_dslot[1];
            end
            r_dv <= {r_dv[0], sample && c_valid[0]};
            if (clr)           r_occ <= '0;
            else if (kill_now) r_occ <= r_occ - 1'b1;
            else if (load_now) r_occ <= r_occ + 1'b1;
        end
    end

    // Slot numbers travel alongside the distance pipeline.
    always_ff @(posedge i_clk) begin
        r_dslot[0] <= r_pos;
        r_dslot[1] <= r_dslot[0];
    end

    // Result register, held while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_ev    <= 1'b0;
            r_out_x     <= '0;
            r_out_y     <= '0;
            r_out_hit   <= 1'b0;
            r_out_slot  <= '0;
            r_out_found <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            if (out_set)         r_out_valid <= 1'b1;
            else if (accept_out) r_out_valid <= 1'b0;
            if (out_set) begin
                r_out_ev    <= n_out_ev;
                r_out_x     <= n_out_x;
                r_out_y     <= n_out_y;
                r_out_hit   <= n_out_hit;
                r_out_slot  <= n_out_slot;
                r_out_found <= n_out_found;
                r_out_last  <= n_out_last;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_is_eviction = r_out_ev;
    assign o_evicted_x   = r_out_x;
    assign o_evicted_y   = r_out_y;
    assign o_hit         = r_out_hit;
    assign o_slot        = r_out_slot;
    assign o_found       = r_out_found;
    assign o_last        = r_out_last;

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable({o_is_eviction, o_evicted_x,
        o_evicted_y, o_hit, o_slot, o_found, o_last}));

    // Occupancy always equals the number of valid cells.
    a_occ_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(c_valid) == int'(r_occ));

    // A result is only offered from the output state.
    a_out_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_state == ST_OUT);

endmodule

// ===== hw/rtl/ftc_dist.sv =====
// Squared distance from a tile to the cached rectangle, two register stages deep.
module ftc_dist
    import ftc_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                        i_clk,
    input  logic signed [COORD_BITS-1:0] i_x,
    input  logic signed [COORD_BITS-1:0] i_y,
    input  logic signed [COORD_BITS-1:0] i_left,
    input  logic signed [COORD_BITS-1:0] i_top,
    input  logic        [15:0]          i_width,
    input  logic        [15:0]          i_height,
    output logic        [2*COORD_BITS+2:0] o_dist2
);
    localparam int EW = COORD_BITS + 18;
    localparam int GW = COORD_BITS + 2;

    logic signed [EW-1:0] xs, ys, xl, yt, xh, yh;
    logic        [GW-1:0] gx, gy;
    logic        [COORD_BITS+1:0] r_gx, r_gy;
    logic        [2*COORD_BITS+3:0] sq_x, sq_y;

    // Gap along each axis, clamped to zero inside the span.
    // The gap never exceeds 2^COORD_BITS, so COORD_BITS+2 bits hold it.
    always_comb begin
        xs = EW'(i_x);
        ys = EW'(i_y);
        xl = EW'(i_left);
        yt = EW'(i_top);
        xh = xl + EW'($signed({1'b0, i_width})) - EW'(1);
        yh = yt + EW'($signed({1'b0, i_height})) - EW'(1);
        if (xs < xl)      gx = GW'(xl - xs);
        else if (xs > xh) gx = GW'(xs - xh);
        else              gx = '0;
        if (ys < yt)      gy = GW'(yt - ys);
        else if (ys > yh) gy = GW'(ys - yh);
        else              gy = '0;
    end

    // First stage holds the gaps.
    always_ff @(posedge i_clk) begin
        r_gx <= gx;
        r_gy <= gy;
    end

    assign sq_x = (2*COORD_BITS+4)'(r_gx) * (2*COORD_BITS+4)'(r_gx);
    assign sq_y = (2*COORD_BITS+4)'(r_gy) * (2*COORD_BITS+4)'(r_gy);

    // Second stage holds the sum of squares.
    always_ff @(posedge i_clk) begin
        o_dist2 <= sq_x[2*COORD_BITS+2:0] + sq_y[2*COORD_BITS+2:0];
    end
endmodule

// ===== hw/rtl/ftc_cell.sv =====
// One slot of the tag chain: holds a tag and rotates it to its neighbor on a shift.
module ftc_cell
    import ftc_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_shift,
    input  logic                  i_clear,
    input  logic                  i_load,
    input  logic                  i_kill,
    input  logic                  i_valid,
    input  logic [COORD_BITS-1:0] i_col,
    input  logic [COORD_BITS-1:0] i_row,
    input  logic [COORD_BITS-1:0] i_new_col,
    input  logic [COORD_BITS-1:0] i_new_row,
    output logic                  o_valid,
    output logic [COORD_BITS-1:0] o_col,
    output logic [COORD_BITS-1:0] o_row
);
    // Valid bit: shifted with the tag, set on load, dropped on kill or clear.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            o_valid <= 1'b0;
        end else if (i_shift) begin
            o_valid <= i_valid;
        end else if (i_load) begin
            o_valid <= 1'b1;
        end else if (i_kill) begin
            o_valid <= 1'b0;
        end
    end

    // Tag payload.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            o_col <= i_col;
            o_row <= i_row;
        end else if (i_load) begin
            o_col <= i_new_col;
            o_row <= i_new_row;
        end
    end
endmodule
